// ===== hw/rtl/bnp_pkg.sv =====
package bnp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 5;
  localparam int CHAR_W     = 7;
  localparam int DIGITS     = VALUE_BITS;
  localparam int IDX_W      = $clog2(DIGITS);
  localparam int CNT_W      = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(21);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_W'(10));
  endfunction

endpackage

// ===== hw/rtl/bnp_divider.sv =====
module bnp_divider
  import bnp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  logic                 running;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [RADIX_W-1:0]   div;
  logic [DIGIT_W:0]     partial;
  logic                 fits;
  logic [DIGIT_W:0]     partial_next;

  always_comb begin
    partial      = {remainder, quotient[VALUE_BITS-1]};
    fits         = partial >= {1'b0, div};
    partial_next = fits ? partial - {1'b0, div} : partial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        bit_cnt   <= '0;
        div       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (running) begin
        remainder <= partial_next[DIGIT_W-1:0];
        quotient  <= {quotient[VALUE_BITS-2:0], fits};
        bit_cnt   <= bit_cnt + BIT_CNT_W'(1);
        if (bit_cnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/base_n_digits_palindrome_core.sv =====
// Writes value in the base held by the radix register (2 to 21; lower codes act as 2,
// higher as 21) as ASCII digits '0'-'9','A'-'K', most significant first, one per strobe
// cycle; the final digit has is_last set and is_palindrome tells whether the string reads
// the same reversed. A request is taken when start is high and busy is low. Each digit is
// produced by a one-bit-per-cycle long division, and the divider is restarted on the quotient
// as soon as it is done, until the quotient is zero.
// The digits then stream out on consecutive cycles; the receiver cannot stall them and
// must take each one in the cycle strobe is high. Write radix only while busy is low.
module base_n_digits_palindrome_core
  import bnp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  strobe,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  is_last,
  output logic                  is_palindrome
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    EMIT
  } state_t;

  state_t               state;
  logic [RADIX_W-1:0]   radix;
  logic [RADIX_W-1:0]   base;
  logic [RADIX_W-1:0]   base_next;
  logic [DIGIT_W-1:0]   msd_first [DIGITS];
  logic [DIGIT_W-1:0]   lsd_first [DIGITS];
  logic [CNT_W-1:0]     ndig;
  logic                 pal;
  logic                 pal_next;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [DIGIT_W-1:0]    div_remainder;

  assign busy = state != IDLE;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_next = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_next = RADIX_MAX;
    end else begin
      base_next = radix;
    end
    div_start    = 1'b0;
    div_dividend = value;
    if (state == IDLE && start) begin
      div_start = 1'b1;
    end else if (state == DIVIDE && div_done && div_quotient != '0) begin
      div_start    = 1'b1;
      div_dividend = div_quotient;
    end
    pal_next = pal && (msd_first[0] == lsd_first[0]);
  end

  bnp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((state == IDLE) ? base_next : base),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      radix  <= RADIX_RESET;
      strobe <= 1'b0;
      ndig   <= '0;
      pal    <= 1'b1;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        radix <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            base  <= base_next;
            ndig  <= '0;
            pal   <= 1'b1;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            for (int i = DIGITS - 1; i > 0; i--) begin
              msd_first[i] <= msd_first[i-1];
            end
            msd_first[0] <= div_remainder;
            if (ndig < CNT_W'(DIGITS)) begin
              lsd_first[ndig[IDX_W-1:0]] <= div_remainder;
              ndig <= ndig + CNT_W'(1);
            end
            if (div_quotient == '0) begin
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          // pop the top digit, compare it against its mirror
          strobe        <= 1'b1;
          digit_char    <= digit_glyph(msd_first[0]);
          is_last       <= ndig == CNT_W'(1);
          is_palindrome <= (ndig == CNT_W'(1)) && pal_next;
          pal           <= pal_next;
          for (int i = 0; i < DIGITS - 1; i++) begin
            msd_first[i] <= msd_first[i+1];
            lsd_first[i] <= lsd_first[i+1];
          end
          ndig <= ndig - CNT_W'(1);
          if (ndig == CNT_W'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
